// ===== rtl/wto_pkg.sv =====
package wto_pkg;

  // field widths fixed by the interface
  localparam int PHASE_W      = 32;
  localparam int INT_W        = 16;
  localparam int LEN_W        = 9;
  localparam int SAMPLE_W     = 8;
  localparam int FRAC_HI_W    = 8;
  localparam int IN_ADDR_W    = 9;
  localparam int OP_W         = 2;
  localparam int CFG_IDX_W    = 1;
  localparam int IN_DATA_W    = 24;
  localparam int OUT_DATA_W   = 8;

  // log2 of the wave memory depth, 2 .. 16
  localparam int TABLE_ADDR_W_DEF = 9;

  // reset values of the registers
  localparam logic [PHASE_W-1:0] PHASE_STEP_RST   = '0;
  localparam logic [LEN_W-1:0]   TABLE_LENGTH_RST = 9'd256;

  // weight of the aft sample is this minus the fraction high byte
  localparam logic [FRAC_HI_W-1:0] WEIGHT_FULL = 8'd255;

  // operation codes on in_tuser
  typedef enum logic [OP_W-1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_LENGTH = 1'd1;

  // status of the stage holding the memory read data
  typedef struct packed {
    logic                 valid;
    logic [FRAC_HI_W-1:0] frac;
  } wto_tap_t;

endpackage

// ===== rtl/wavetable_oscillator_unit.sv =====
// a tick word is read into the memory read registers at acceptance, then moves to the output register
// that drives out_tdata; reads start at acceptance
// throughput: one input word per cycle when not stalled; write and clear words finish at acceptance
// input stalls only while the tap stage is full and the result word is held by out_tready
// reset (rst_n low, synchronous) clears phase to 0, phase_step to 0, table_length to 256
// wave memory contents are not reset and must be written before they are read
module wavetable_oscillator_unit #(
  parameter int TABLE_ADDR_W = wto_pkg::TABLE_ADDR_W_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input words
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [wto_pkg::IN_DATA_W-1:0]       in_tdata,   // table_address[8:0], table_sample[16:9]
  input  logic [wto_pkg::OP_W-1:0]            in_tuser,   // op[1:0]
  // result words
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [wto_pkg::OUT_DATA_W-1:0]      out_tdata,  // audio_sample[7:0]
  // configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [wto_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [wto_pkg::PHASE_W-1:0]         cfg_data
);

  logic                          in_acc;
  wto_pkg::op_t                  op;
  logic                          tick_acc;
  logic                          write_acc;
  logic                          clear_acc;
  logic                          take;
  wto_pkg::wto_tap_t             tap;
  logic [TABLE_ADDR_W-1:0]       addr_aft;
  logic [TABLE_ADDR_W-1:0]       addr_fore;
  logic [wto_pkg::INT_W-1:0]     wr_addr_ext;
  logic [TABLE_ADDR_W-1:0]       wr_addr;
  logic [wto_pkg::SAMPLE_W-1:0]  wr_sample;
  logic [wto_pkg::SAMPLE_W-1:0]  sample_aft;
  logic [wto_pkg::SAMPLE_W-1:0]  sample_fore;

  // handshake and op decode
  assign cfg_ready = 1'b1;
  assign in_tready = !tap.valid || take;
  assign in_acc    = in_tvalid && in_tready;
  assign op        = wto_pkg::op_t'(in_tuser);

  always_comb begin
    tick_acc  = 1'b0;
    write_acc = 1'b0;
    clear_acc = 1'b0;
    unique case (op)
      wto_pkg::OP_TICK:  tick_acc  = in_acc;
      wto_pkg::OP_WRITE: write_acc = in_acc;
      wto_pkg::OP_CLEAR: clear_acc = in_acc;
      default:           tick_acc  = 1'b0;
    endcase
  end

  // write address wraps at the memory depth
  assign wr_addr_ext = wto_pkg::INT_W'(in_tdata[wto_pkg::IN_ADDR_W-1:0]);
  assign wr_addr     = wr_addr_ext[TABLE_ADDR_W-1:0];
  assign wr_sample   = in_tdata[wto_pkg::IN_ADDR_W+wto_pkg::SAMPLE_W-1:wto_pkg::IN_ADDR_W];

  wto_phase #(
    .ADDR_W    (TABLE_ADDR_W)
  ) u_phase (
    .clk       (clk),
    .rst_n     (rst_n),
    .tick_acc  (tick_acc),
    .clear_acc (clear_acc),
    .take      (take),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_idx   (cfg_index),
    .cfg_wdata (cfg_data),
    .addr_aft  (addr_aft),
    .addr_fore (addr_fore),
    .tap       (tap)
  );

  // two copies of the table, same writes, one read each
  wto_wave_mem #(
    .ADDR_W  (TABLE_ADDR_W)
  ) u_mem_aft (
    .clk     (clk),
    .wr_en   (write_acc),
    .wr_addr (wr_addr),
    .wr_data (wr_sample),
    .rd_en   (tick_acc),
    .rd_addr (addr_aft),
    .rd_data (sample_aft)
  );

  wto_wave_mem #(
    .ADDR_W  (TABLE_ADDR_W)
  ) u_mem_fore (
    .clk     (clk),
    .wr_en   (write_acc),
    .wr_addr (wr_addr),
    .wr_data (wr_sample),
    .rd_en   (tick_acc),
    .rd_addr (addr_fore),
    .rd_data (sample_fore)
  );

  wto_interp u_interp (
    .clk         (clk),
    .rst_n       (rst_n),
    .tap         (tap),
    .sample_aft  (sample_aft),
    .sample_fore (sample_fore),
    .out_ready   (out_tready),
    .out_valid   (out_tvalid),
    .out_sample  (out_tdata),
    .take        (take)
  );

  // a tick always lands in the tap stage
  a_tick_tap: assert property (@(posedge clk) disable iff (!rst_n)
    tick_acc |=> tap.valid)
    else $error("tick word lost before interpolation");

  // only ticks fill an empty tap stage
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    (!tap.valid && !tick_acc) |=> !tap.valid)
    else $error("tap stage filled without a tick");

  // a new result word comes only from a filled tap stage
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(tap.valid))
    else $error("result word without a tick");

  // a full tap stage with a stalled output blocks input
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    (tap.valid && out_tvalid && !out_tready) |-> !in_tready)
    else $error("input taken while pipeline is full");

endmodule

// ===== rtl/wto_wave_mem.sv =====
module wto_wave_mem #(
  parameter int ADDR_W = wto_pkg::TABLE_ADDR_W_DEF
) (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [ADDR_W-1:0]             wr_addr,
  input  logic [wto_pkg::SAMPLE_W-1:0]  wr_data,
  input  logic                          rd_en,
  input  logic [ADDR_W-1:0]             rd_addr,
  output logic [wto_pkg::SAMPLE_W-1:0]  rd_data
);

  localparam int DEPTH = 1 << ADDR_W;

  logic [wto_pkg::SAMPLE_W-1:0] mem [DEPTH];
  logic [wto_pkg::SAMPLE_W-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port, holds while not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/wto_phase.sv =====
module wto_phase #(
  parameter int ADDR_W = wto_pkg::TABLE_ADDR_W_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            tick_acc,
  input  logic                            clear_acc,
  input  logic                            take,
  input  logic                            cfg_we,
  input  logic [wto_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [wto_pkg::PHASE_W-1:0]     cfg_wdata,
  output logic [ADDR_W-1:0]               addr_aft,
  output logic [ADDR_W-1:0]               addr_fore,
  output wto_pkg::wto_tap_t               tap
);

  logic [wto_pkg::PHASE_W-1:0]   phase_r, phase_nxt;
  logic [wto_pkg::PHASE_W-1:0]   step_r, step_nxt;
  logic [wto_pkg::LEN_W-1:0]     len_r, len_nxt;
  logic                          valid_r, valid_nxt;
  logic [wto_pkg::FRAC_HI_W-1:0] frac_r, frac_nxt;

  logic [wto_pkg::PHASE_W-1:0]   phase_sum;
  logic [wto_pkg::INT_W-1:0]     ip_raw;
  logic [wto_pkg::INT_W-1:0]     len_ext;
  logic [wto_pkg::INT_W-1:0]     ip;

  // configuration registers
  always_comb begin
    step_nxt = step_r;
    len_nxt  = len_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        wto_pkg::CFG_PHASE_STEP:   step_nxt = cfg_wdata;
        wto_pkg::CFG_TABLE_LENGTH: len_nxt  = cfg_wdata[wto_pkg::LEN_W-1:0];
        default:                   step_nxt = step_r;
      endcase
    end
  end

  // advance and single wrap of the integer part
  assign phase_sum = phase_r + step_r;
  assign ip_raw    = phase_sum[wto_pkg::PHASE_W-1:wto_pkg::PHASE_W-wto_pkg::INT_W];
  assign len_ext   = wto_pkg::INT_W'(len_r);
  assign ip        = (ip_raw >= len_ext) ? (ip_raw - len_ext) : ip_raw;

  always_comb begin
    phase_nxt = phase_r;
    if (clear_acc) begin
      phase_nxt = '0;
    end else if (tick_acc) begin
      phase_nxt = {ip, phase_sum[wto_pkg::PHASE_W-wto_pkg::INT_W-1:0]};
    end
  end

  // read addresses, the fore index wraps at the memory depth
  assign addr_aft  = ip[ADDR_W-1:0];
  assign addr_fore = addr_aft + ADDR_W'(1);

  // tap stage tracks the word sitting in the memory read registers
  always_comb begin
    frac_nxt  = frac_r;
    valid_nxt = valid_r;
    if (tick_acc) begin
      frac_nxt  = phase_sum[wto_pkg::PHASE_W-wto_pkg::INT_W-1:
                            wto_pkg::PHASE_W-wto_pkg::INT_W-wto_pkg::FRAC_HI_W];
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      step_r  <= wto_pkg::PHASE_STEP_RST;
      len_r   <= wto_pkg::TABLE_LENGTH_RST;
      valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      step_r  <= step_nxt;
      len_r   <= len_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    frac_r <= frac_nxt;
  end

  assign tap.valid = valid_r;
  assign tap.frac  = frac_r;

  // a clear leaves the phase at zero
  a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
    clear_acc |=> (phase_r == '0))
    else $error("phase not cleared");

  // the stored integer part never exceeds what one wrap can leave
  a_tick_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (tick_acc && (ip_raw >= len_ext)) |=>
      (phase_r[wto_pkg::PHASE_W-1:wto_pkg::PHASE_W-wto_pkg::INT_W] ==
       $past(ip_raw) - $past(len_ext)))
    else $error("phase wrap wrong");

endmodule

// ===== rtl/wto_interp.sv =====
module wto_interp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  wto_pkg::wto_tap_t                 tap,
  input  logic [wto_pkg::SAMPLE_W-1:0]      sample_aft,
  input  logic [wto_pkg::SAMPLE_W-1:0]      sample_fore,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic [wto_pkg::SAMPLE_W-1:0]      out_sample,
  output logic                              take
);

  localparam int PROD_W = 18;
  localparam int MIX_W  = 16;

  logic [wto_pkg::FRAC_HI_W-1:0] w_aft;
  logic signed [PROD_W-1:0]      prod_aft;
  logic signed [PROD_W-1:0]      prod_fore;
  logic signed [PROD_W-1:0]      mix;
  logic [MIX_W-1:0]              mix_lo;
  logic [wto_pkg::SAMPLE_W-1:0]  rounded;

  logic                          valid_r, valid_nxt;
  logic [wto_pkg::SAMPLE_W-1:0]  data_r, data_nxt;

  // weighted sum of the two neighbors
  assign w_aft     = wto_pkg::WEIGHT_FULL - tap.frac;
  assign prod_aft  = PROD_W'($signed(sample_aft)) *
                     $signed(PROD_W'(w_aft));
  assign prod_fore = PROD_W'($signed(sample_fore)) *
                     $signed(PROD_W'(tap.frac));
  assign mix       = prod_aft + prod_fore;
  assign mix_lo    = mix[MIX_W-1:0];

  // round on bit 7 of the low byte, keep the high byte
  assign rounded = mix_lo[MIX_W-1:wto_pkg::SAMPLE_W] +
                   wto_pkg::SAMPLE_W'(mix_lo[wto_pkg::SAMPLE_W-1]);

  // output register, free when empty or drained this cycle
  assign take = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    if (take) begin
      valid_nxt = tap.valid;
      data_nxt  = rounded;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign out_valid  = valid_r;
  assign out_sample = data_r;

endmodule

// ===== dv/wto_checker.sv =====
module wto_checker
  import wto_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // table_address[8:0], table_sample[16:9], zero pad
  input  logic [OP_W-1:0]       in_tuser,   // op[1:0]
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,  // audio_sample[7:0]
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [PHASE_W-1:0]    cfg_data,
  output int                    samples_owed,
  output int                    error_count
);

  localparam int DEPTH = 1 << TABLE_ADDR_W_DEF;

  // shadow of the oscillator state
  logic [PHASE_W-1:0]  step_reg;
  logic [LEN_W-1:0]    length_reg;
  logic [PHASE_W-1:0]  phase_acc;
  logic [SAMPLE_W-1:0] wave_copy [DEPTH];

  // audio samples owed by the block, oldest first
  logic [SAMPLE_W-1:0] expected_samples [$];
  logic [SAMPLE_W-1:0] want;
  int                  sample_no;

  initial begin
    samples_owed = 0;
    error_count  = 0;
  end

  task automatic report_mismatch(input string what);
    error_count++;
    $display("[%0t] wto_checker: %s", $time, what);
  endtask

  // advance the phase by one step and interpolate between the two taps
  function automatic logic [SAMPLE_W-1:0] next_audio_sample();
    logic [INT_W-1:0]            idx;
    logic [FRAC_HI_W-1:0]        frac;
    logic [TABLE_ADDR_W_DEF-1:0] aft_addr;
    logic [TABLE_ADDR_W_DEF-1:0] fore_addr;
    int                          aft;
    int                          fore;
    int                          mix;
    logic [15:0]                 low16;
    phase_acc = phase_acc + step_reg;
    idx  = phase_acc[PHASE_W-1 -: INT_W];
    frac = phase_acc[INT_W-1 -: FRAC_HI_W];
    // a single wrap only, the index may still sit past the length
    if (idx >= INT_W'(length_reg)) begin
      idx = idx - INT_W'(length_reg);
      phase_acc[PHASE_W-1 -: INT_W] = idx;
    end
    aft_addr  = idx[TABLE_ADDR_W_DEF-1:0];
    fore_addr = aft_addr + 1'b1;
    aft  = $signed(wave_copy[aft_addr]);
    fore = $signed(wave_copy[fore_addr]);
    mix  = aft * (int'(WEIGHT_FULL) - int'(frac)) + fore * int'(frac);
    low16 = mix[15:0];
    // round on bit 7, wraps in 8 bits
    return low16[15:8] + {7'd0, low16[7]};
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      step_reg   = PHASE_STEP_RST;
      length_reg = TABLE_LENGTH_RST;
      phase_acc  = '0;
      sample_no  = 0;
      expected_samples.delete();
    end else begin
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_PHASE_STEP:   step_reg = cfg_data;
          CFG_TABLE_LENGTH: length_reg = cfg_data[LEN_W-1:0];
          default: ;
        endcase
      end
      // result words against the oldest expectation
      if (out_tvalid && out_tready) begin
        if (expected_samples.size() == 0) begin
          report_mismatch($sformatf("audio_sample %0d with no tick outstanding",
                                    $signed(out_tdata)));
        end else begin
          want = expected_samples.pop_front();
          if (out_tdata !== want)
            report_mismatch($sformatf("sample %0d: audio_sample got %0d expected %0d",
                                      sample_no, $signed(out_tdata), $signed(want)));
        end
        sample_no++;
      end
      // input words
      if (in_tvalid && in_tready) begin
        case (op_t'(in_tuser))
          OP_TICK:  expected_samples.push_back(next_audio_sample());
          OP_WRITE: wave_copy[in_tdata[TABLE_ADDR_W_DEF-1:0]] = in_tdata[IN_ADDR_W +: SAMPLE_W];
          OP_CLEAR: phase_acc = '0;
          default: ;
        endcase
      end
    end
    samples_owed = expected_samples.size();
  end

endmodule

// ===== dv/tb.sv =====
module tb;
  import wto_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int DEPTH         = 1 << TABLE_ADDR_W_DEF;
  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 4;
  localparam int RANDOM_ITEMS  = 416;
  localparam int RANDOM_PHASES = 8;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic [OP_W-1:0]       in_tuser   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [PHASE_W-1:0]    cfg_data   = '0;

  int samples_owed;
  int error_count;
  int idle_cycles = 0;
  bit dense_input = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  wavetable_oscillator_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  wto_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .samples_owed (samples_owed),
    .error_count  (error_count)
  );

  // watchdog on cycles without any accepted word
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)
        || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("wavetable_oscillator_unit verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side back-pressure, with long stretches of steady ready
  initial begin
    int r;
    forever begin
      r = $urandom_range(0, 99);
      out_tready <= 1'b1;
      if (r < 25) begin
        repeat ($urandom_range(40, 200)) @(negedge clk);
      end else begin
        repeat ($urandom_range(1, 8)) @(negedge clk);
        out_tready <= 1'b0;
        if (r < 92) repeat ($urandom_range(1, 3)) @(negedge clk);
        else repeat ($urandom_range(10, 40)) @(negedge clk);
      end
    end
  end

  function automatic int pick_gap(input bit dense);
    int r;
    r = $urandom_range(0, 99);
    if (dense || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // one input word, valid left high for a back-to-back follower
  task automatic send_word(input logic [OP_W-1:0] op, input logic [IN_ADDR_W-1:0] addr,
                           input logic [SAMPLE_W-1:0] sample);
    int gap;
    gap = pick_gap(dense_input);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {{(IN_DATA_W-IN_ADDR_W-SAMPLE_W){1'b0}}, sample, addr};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic random_word();
    int r;
    r = $urandom_range(0, 99);
    if (r < 62)
      send_word(OP_TICK, IN_ADDR_W'($urandom), SAMPLE_W'($urandom));
    else if (r < 84)
      send_word(OP_WRITE, IN_ADDR_W'($urandom_range(0, DEPTH-1)), SAMPLE_W'($urandom));
    else if (r < 94)
      send_word(OP_CLEAR, IN_ADDR_W'($urandom), SAMPLE_W'($urandom));
    else
      send_word(OP_UNUSED, IN_ADDR_W'($urandom), SAMPLE_W'($urandom));
  endtask

  // hold the sender until every owed sample is out and the pipe is empty
  task automatic settle();
    in_tvalid <= 1'b0;
    while (samples_owed != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PHASE_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic apply_setting(input logic [PHASE_W-1:0] step, input logic [LEN_W-1:0] len);
    settle();
    write_reg(CFG_PHASE_STEP, step);
    write_reg(CFG_TABLE_LENGTH, PHASE_W'(len));
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [PHASE_W-1:0] random_step();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return '1;
    if (r < 30) return $urandom;
    return $urandom_range(1, 32'h0004_0000);
  endfunction

  function automatic logic [LEN_W-1:0] random_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return 9'd1;
    if (r < 30) return 9'd511;
    return LEN_W'($urandom_range(1, 511));
  endfunction

  initial begin
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // load every table entry so that no read hits an unwritten one
    for (int a = 0; a < DEPTH; a++) send_word(OP_WRITE, IN_ADDR_W'(a), SAMPLE_W'($urandom));

    // full-scale samples at both table ends, half-way fraction
    apply_setting(32'h0000_8000, 9'd256);
    send_word(OP_WRITE, 9'd0, 8'h80);
    send_word(OP_WRITE, 9'd1, 8'h7F);
    send_word(OP_WRITE, 9'd511, 8'h7F);
    send_word(OP_WRITE, 9'd510, 8'h80);
    send_word(OP_CLEAR, 9'h1FF, 8'hFF);
    send_word(OP_TICK, 9'h1FF, 8'hFF);
    send_word(OP_TICK, 9'd0, 8'd0);
    send_word(OP_UNUSED, 9'h1FF, 8'hFF);

    // zero length: last entry, guard read wraps to entry 0, then past the table
    apply_setting(32'h01FF_FF00, 9'd0);
    send_word(OP_CLEAR, 9'd0, 8'd0);
    send_word(OP_TICK, 9'd0, 8'd0);
    send_word(OP_TICK, 9'd0, 8'd0);

    // largest step, index left far out of range after one wrap
    apply_setting(32'hFFFF_FFFF, 9'd511);
    send_word(OP_CLEAR, 9'd0, 8'd0);
    send_word(OP_TICK, 9'd0, 8'd0);
    send_word(OP_TICK, 9'd0, 8'd0);

    // length shrunk under a large phase, zero step
    apply_setting(32'h0000_0000, 9'd1);
    send_word(OP_TICK, 9'd0, 8'd0);
    send_word(OP_TICK, 9'd0, 8'd0);
    send_word(OP_CLEAR, 9'd0, 8'd0);
    send_word(OP_TICK, 9'd0, 8'd0);

    // fraction high byte at its top
    apply_setting(32'h0000_FFFF, 9'd1);
    send_word(OP_TICK, 9'd0, 8'd0);
    send_word(OP_TICK, 9'd0, 8'd0);

    // random phases under random settings
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      apply_setting(random_step(), random_length());
      for (int i = 0; i < RANDOM_ITEMS / RANDOM_PHASES; i++) begin
        if ($urandom_range(0, 39) == 0) dense_input = !dense_input;
        if (p == 3 && i == 30) settle();
        random_word();
      end
    end

    settle();
    if (error_count == 0)
      $display("wavetable_oscillator_unit verification clean");
    else
      $display("wavetable_oscillator_unit verification failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/wto_pkg.sv
rtl/wto_wave_mem.sv
rtl/wto_phase.sv
rtl/wto_interp.sv
rtl/wavetable_oscillator_unit.sv
dv/wto_checker.sv
dv/tb.sv
